### src/hrhp_pkg.sv
`default_nettype none
package hrhp_pkg;

  // verdict codes
  localparam logic [2:0] V_LEN_OK     = 3'd0;
  localparam logic [2:0] V_REDIRECT   = 3'd1;
  localparam logic [2:0] V_BAD_STATUS = 3'd2;
  localparam logic [2:0] V_BAD_CODE   = 3'd3;
  localparam logic [2:0] V_BAD_HEADER = 3'd4;
  localparam logic [2:0] V_NO_KEY     = 3'd5;
  localparam logic [2:0] V_BAD_LENGTH = 3'd6;
  localparam logic [2:0] V_TOO_LONG   = 3'd7;

  // register indexes
  localparam logic [1:0] REG_HEAD_LIMIT = 2'd0;
  localparam logic [1:0] REG_LEN_KEY    = 2'd1;
  localparam logic [1:0] REG_LOC_KEY    = 2'd2;

  localparam logic [14:0] HEAD_LIMIT_RST = 15'd16384;
  localparam logic [31:0] LEN_KEY_RST    = 32'h12bc2f1c;
  localparam logic [31:0] LOC_KEY_RST    = 32'h5e9e89cb;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [15:0] CODE_OK    = 16'd200;
  localparam logic [15:0] CODE_MOVED = 16'd301;
  localparam logic [15:0] CODE_FOUND = 16'd302;

  localparam logic [63:0] MAX_8BIT  = 64'd255;
  localparam logic [63:0] MAX_16BIT = 64'd65535;
  localparam logic [63:0] MAX_LEN   = 64'h7fff_ffff_ffff_ffff;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  typedef struct packed {
    logic [14:0] head_limit;
    logic [31:0] len_key;
    logic [31:0] loc_key;
  } cfg_t;

  typedef struct packed {
    logic [14:0] value_length;
    logic [14:0] value_offset;
    logic [14:0] head_length;
    logic [62:0] content_length;
    logic [7:0]  version_minor;
    logic [7:0]  version_major;
    logic [15:0] status_code;
    logic [2:0]  verdict;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  // a*10+d, saturating at max
  function automatic logic [63:0] acc_digit(input logic [63:0] a, input logic [3:0] d,
                                            input logic [63:0] max);
    logic [66:0] t;
    t = ({3'd0, a} << 3) + ({3'd0, a} << 1) + {63'd0, d};
    return (t > {3'd0, max}) ? max : t[63:0];
  endfunction

  // expected lowercase letters of the protocol tag
  function automatic logic [7:0] proto_char(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h68;
      2'd1: r = 8'h74;
      2'd2: r = 8'h74;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/hrhp_core.sv
`default_nettype none
module hrhp_core #(
  parameter int HEAD_MAX = 16384
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first_byte,
  input  wire hrhp_pkg::cfg_t  cfg,
  output logic                 res_valid,
  output hrhp_pkg::result_t    res
);
  import hrhp_pkg::*;

  localparam int POS_W = $clog2(HEAD_MAX + 1);
  localparam int LIM_W = ((POS_W > 15) ? POS_W : 15) + 1;

  typedef enum logic [3:0] {
    P_IDLE, P_PROTO, P_MAJOR, P_MINOR, P_CODE, P_CODE_CR, P_REASON,
    P_LSTART, P_LCR, P_NAME, P_VAL, P_MLEAD, P_MDIG, P_MTEXT
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [15:0]        acc, acc_next;
  logic [31:0]        crc, crc_next;
  logic [31:0]        key, key_next;
  logic [15:0]        st, st_next;
  logic [7:0]         mj, mj_next, mn, mn_next;
  logic               md, md_next;
  logic [62:0]        ml, ml_next;
  logic [POS_W-1:0]   mvs, mvs_next, mve, mve_next;
  logic               pcr, pcr_next;
  logic               lb, lb_next;
  logic               fin, fin_next;

  logic               fire;
  logic               v;
  logic [2:0]         vc;
  logic [POS_W-1:0]   p;
  logic               dig;
  logic [3:0]         dv;
  logic [31:0]        crc_src, crc_new;
  logic [LIM_W-1:0]   lim;
  phase_t             ph2;

  assign dig = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign dv  = data_byte[3:0];

  always_comb begin
    // base values: cleared on the first beat of a response
    phase_next = first_byte ? P_PROTO : phase;
    pos_next   = first_byte ? '0 : pos;
    acc_next   = first_byte ? '0 : acc;
    crc_next   = first_byte ? CRC_INIT : crc;
    key_next   = first_byte ? '0 : key;
    st_next    = first_byte ? '0 : st;
    mj_next    = first_byte ? '0 : mj;
    mn_next    = first_byte ? '0 : mn;
    md_next    = first_byte ? 1'b0 : md;
    ml_next    = first_byte ? '0 : ml;
    mvs_next   = first_byte ? '0 : mvs;
    mve_next   = first_byte ? '0 : mve;
    pcr_next   = first_byte ? 1'b0 : pcr;
    lb_next    = first_byte ? 1'b0 : lb;
    fin_next   = first_byte ? 1'b0 : fin;
    fire       = step && (first_byte || !fin);
    p          = pos_next;
    v          = 1'b0;
    vc         = V_LEN_OK;
    ph2        = phase_next;
    crc_src    = (phase_next == P_LSTART) ? CRC_INIT : crc_next;
    crc_new    = crc_byte(crc_src, data_byte | CASE_BIT);
    if (fire) begin
      pos_next = p + 1'b1;
    end

    unique case (phase_next)
      P_PROTO: begin
        if ((p < POS_W'(4)) ? ((data_byte | CASE_BIT) != proto_char(p[1:0]))
                             : (data_byte != CH_SLASH)) begin
          v = 1'b1; vc = V_BAD_STATUS;
        end else if (p >= POS_W'(4)) begin
          phase_next = P_MAJOR; acc_next = '0;
        end
      end
      P_MAJOR: begin
        if (dig) acc_next = 16'(acc_digit(64'(acc_next), dv, MAX_8BIT));
        else if (data_byte == CH_DOT) begin
          mj_next = acc_next[7:0]; acc_next = '0; phase_next = P_MINOR;
        end else begin
          v = 1'b1; vc = V_BAD_STATUS;
        end
      end
      P_MINOR: begin
        if (dig) acc_next = 16'(acc_digit(64'(acc_next), dv, MAX_8BIT));
        else if (data_byte == CH_SP) begin
          mn_next = acc_next[7:0]; acc_next = '0; phase_next = P_CODE;
        end else begin
          v = 1'b1; vc = V_BAD_STATUS;
        end
      end
      P_CODE: begin
        if (dig) acc_next = 16'(acc_digit(64'(acc_next), dv, MAX_16BIT));
        else if (data_byte == CH_SP) begin
          st_next = acc_next; pcr_next = 1'b0; phase_next = P_REASON;
        end else if (data_byte == CH_CR) begin
          st_next = acc_next; phase_next = P_CODE_CR;
        end else begin
          v = 1'b1; vc = V_BAD_STATUS;
        end
      end
      P_CODE_CR, P_REASON: begin
        if (data_byte == CH_LF) begin
          if (phase_next == P_REASON && !pcr_next) begin
            v = 1'b1; vc = V_BAD_STATUS;
          end else begin
            // status line complete: pick the wanted key
            phase_next = P_LSTART;
            if (st_next == CODE_OK) key_next = cfg.len_key;
            else if (st_next == CODE_MOVED || st_next == CODE_FOUND) key_next = cfg.loc_key;
            else begin
              v = 1'b1; vc = V_BAD_CODE;
            end
          end
        end else if (phase_next == P_CODE_CR) begin
          v = 1'b1; vc = V_BAD_STATUS;
        end else begin
          pcr_next = (data_byte == CH_CR);
        end
      end
      P_LSTART, P_LCR, P_NAME: begin
        if (phase_next == P_LSTART && data_byte == CH_CR) begin
          crc_next = crc_new; phase_next = P_LCR;
        end else if (phase_next == P_LCR && data_byte == CH_LF) begin
          // blank line ends the head
          v = 1'b1;
          if (!md_next) vc = V_NO_KEY;
          else if (st_next == CODE_OK) vc = (lb_next || ml_next == '0) ? V_BAD_LENGTH : V_LEN_OK;
          else vc = V_REDIRECT;
        end else if (data_byte == CH_LF) begin
          v = 1'b1; vc = V_BAD_HEADER;
        end else if (data_byte == CH_COLON) begin
          pcr_next = 1'b0;
          if (!md_next && (~crc_src) == key_next) begin
            md_next = 1'b1; mvs_next = p + 1'b1; ml_next = '0; lb_next = 1'b0;
            phase_next = (st_next == CODE_OK) ? P_MLEAD : P_MTEXT;
          end else begin
            phase_next = P_VAL;
          end
        end else begin
          crc_next = crc_new; phase_next = P_NAME;
        end
      end
      P_VAL, P_MLEAD, P_MDIG, P_MTEXT: begin
        if (data_byte == CH_LF) begin
          if (!pcr_next) begin
            v = 1'b1; vc = V_BAD_HEADER;
          end else begin
            if (phase_next != P_VAL) mve_next = p - 1'b1;
            pcr_next = 1'b0; phase_next = P_LSTART;
          end
        end else begin
          // a CR inside the value spoils a length
          if (pcr_next && (ph2 == P_MLEAD || ph2 == P_MDIG)) begin
            lb_next = 1'b1; ph2 = P_MTEXT;
          end
          phase_next = ph2;
          if (data_byte == CH_CR) pcr_next = 1'b1;
          else begin
            pcr_next = 1'b0;
            if (ph2 == P_MLEAD) begin
              if (dig) begin
                ml_next = {59'd0, dv}; phase_next = P_MDIG;
              end else if (data_byte != CH_SP && data_byte != CH_TAB) begin
                lb_next = 1'b1; phase_next = P_MTEXT;
              end
            end else if (ph2 == P_MDIG) begin
              if (dig) ml_next = 63'(acc_digit({1'b0, ml_next}, dv, MAX_LEN));
              else begin
                lb_next = 1'b1; phase_next = P_MTEXT;
              end
            end
          end
        end
      end
      default: begin
        v = 1'b1; vc = V_BAD_STATUS;
      end
    endcase

    // head limit, clamped to 1..HEAD_MAX
    lim = LIM_W'(cfg.head_limit);
    if (lim == '0) lim = LIM_W'(1);
    if (lim > LIM_W'(HEAD_MAX)) lim = LIM_W'(HEAD_MAX);
    if (!v && LIM_W'(pos_next) >= lim) begin
      v = 1'b1; vc = V_TOO_LONG;
    end

    res_valid = fire && v;
    res.verdict        = vc;
    res.status_code    = st_next;
    res.version_major  = mj_next;
    res.version_minor  = mn_next;
    res.content_length = (vc == V_LEN_OK) ? ml_next : '0;
    res.head_length    = 15'(pos_next);
    if (md_next && (vc == V_LEN_OK || vc == V_REDIRECT || vc == V_BAD_LENGTH)) begin
      res.value_offset = 15'(mvs_next);
      res.value_length = (mve_next >= mvs_next) ? 15'(mve_next - mvs_next) : '0;
    end else begin
      res.value_offset = '0;
      res.value_length = '0;
    end
    if (v) begin
      fin_next = 1'b1; phase_next = P_IDLE;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; pos <= '0; acc <= '0; crc <= CRC_INIT; key <= '0;
      st <= '0; mj <= '0; mn <= '0; md <= 1'b0; ml <= '0; mvs <= '0; mve <= '0;
      pcr <= 1'b0; lb <= 1'b0; fin <= 1'b1;
    end else if (fire) begin
      phase <= phase_next; pos <= pos_next; acc <= acc_next; crc <= crc_next;
      key <= key_next; st <= st_next; mj <= mj_next; mn <= mn_next; md <= md_next;
      ml <= ml_next; mvs <= mvs_next; mve <= mve_next; pcr <= pcr_next;
      lb <= lb_next; fin <= fin_next;
    end
  end

  // a verdict always leaves the parser idle
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> fin && phase == P_IDLE)
    else $error("parser not idle after verdict");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    !fin |-> pos <= POS_W'(HEAD_MAX))
    else $error("byte position past head maximum");
  a_match_start: assert property (@(posedge clk) disable iff (rst)
    md |-> mvs != '0)
    else $error("match without value start");

endmodule
`default_nettype wire

### src/http_response_head_parser.sv
`default_nettype none
// Channel  Dir  Beat contents
// s_*      in   one head byte: tdata[7:0] data_byte, tuser first_byte
// m_*      out  one verdict per response (fields in tdata, see port)
// cfg_*    in   register write: 0 head_limit, 1 length_key_hash, 2 location_key_hash
//
// One byte per cycle while the output is not stalled: a byte enters the
// input register, and the parse step runs from there into the result register.
// rst is synchronous, active high; the parser then idles until a first byte.
// A stalled result holds the result register; the input register keeps
// taking a beat as long as the result register is free or being emptied.
module http_response_head_parser #(
  parameter int HEAD_MAX = 16384
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
  input  wire logic         s_tuser,   // [0] first_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [2:0] verdict, [18:3] status_code, [26:19] version_major,
  // [34:27] version_minor, [97:35] content_length, [112:98] head_length,
  // [127:113] value_offset, [142:128] value_length, [143] zero
  output logic [143:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import hrhp_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_limit <= HEAD_LIMIT_RST;
      cfg.len_key    <= LEN_KEY_RST;
      cfg.loc_key    <= LOC_KEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD_LIMIT: cfg.head_limit <= cfg_data[14:0];
        REG_LEN_KEY:    cfg.len_key    <= cfg_data;
        REG_LOC_KEY:    cfg.loc_key    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_tready) in_valid <= s_tvalid;
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  hrhp_core #(.HEAD_MAX(HEAD_MAX)) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .first_byte (in_first),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (step) m_tvalid <= res_valid;
    else if (m_tready) m_tvalid <= 1'b0;
    if (step && res_valid) m_tdata <= {1'b0, res};
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid && $stable(in_byte))
    else $error("input beat lost under output stall");
  a_len_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == V_LEN_OK |-> m_tdata[97:35] != '0)
    else $error("length verdict with zero length");
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != V_LEN_OK |-> m_tdata[97:35] == '0)
    else $error("length given without length verdict");

endmodule
`default_nettype wire
